### src/mswl_pkg.sv
`default_nettype none

package mswl_pkg;

  localparam int unsigned SUM_W = 64;
  localparam int unsigned IDX_W = 32;
  localparam int unsigned SMP_W = 32;
  localparam int unsigned WIN_W = 8;

  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_SEED,
    ST_IDLE,
    ST_ACC,
    ST_HEAD,
    ST_RUN,
    ST_BEST,
    ST_TAIL,
    ST_PUSH
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] value;
    logic             ge;     // signed a >= b, valid for ALU_SUB
  } alu_res_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [SUM_W-1:0] prefix;
  } entry_t;

endpackage

`default_nettype wire

### src/mswl_if.sv
`default_nettype none

interface mswl_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;
  logic               start_req;

  modport source (output valid, output sample, output start_req, input ready);
  modport sink (input valid, input sample, input start_req, output ready);
endinterface

interface mswl_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] best_sum;

  modport source (output valid, output best_sum, input ready);
  modport sink (input valid, input best_sum, output ready);
endinterface

`default_nettype wire

### src/mswl_alu.sv
`default_nettype none

module mswl_alu (
  input  mswl_pkg::alu_req_t req,
  output mswl_pkg::alu_res_t res
);
  import mswl_pkg::*;

  logic [SUM_W:0] ext_a;
  logic [SUM_W:0] ext_b;
  logic           cin;
  logic [SUM_W:0] sum;

  // 65-bit add/subtract, the sign of the difference gives the signed compare
  always_comb begin
    ext_a = {req.a[SUM_W-1], req.a};
    if (req.op == ALU_SUB) begin
      ext_b = ~{req.b[SUM_W-1], req.b};
      cin   = 1'b1;
    end else begin
      ext_b = {req.b[SUM_W-1], req.b};
      cin   = 1'b0;
    end
    sum       = ext_a + ext_b + {{SUM_W{1'b0}}, cin};
    res.value = sum[SUM_W-1:0];
    res.ge    = ~sum[SUM_W];
  end

endmodule

`default_nettype wire

### src/mswl_deque_mem.sv
`default_nettype none

module mswl_deque_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  mswl_pkg::entry_t   wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output mswl_pkg::entry_t   rd_data
);
  import mswl_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### src/mswl_cfg.sv
`default_nettype none

module mswl_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [mswl_pkg::WIN_W-1:0] window_len
);
  import mswl_pkg::*;

  logic [WIN_W-1:0] window_len_r;
  logic [WIN_W-1:0] window_len_nxt;
  logic             wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel & penable & pwrite & pready & ~paddr[2];

  always_comb begin
    window_len_nxt = window_len_r;
    if (wr_hit) begin
      window_len_nxt = pwdata[WIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= WIN_W'(1);
    end else begin
      window_len_r <= window_len_nxt;
    end
  end

  assign prdata     = paddr[2] ? 32'd0 : {{(32-WIN_W){1'b0}}, window_len_r};
  assign window_len = window_len_r;

endmodule

`default_nettype wire

### src/max_sum_window_limited_subarray_unit.sv
// Windowed maximum-subarray tracker.
// in_ch carries one signed sample per item plus start_req, which restarts the
// sequence before the sample is taken in. out_ch returns one best_sum per
// item: the largest sum of a contiguous run of at most window_len samples.
// window_len is written over the APB port at byte address 0 (0 acts as 1,
// values above MAX_WINDOW saturate); write it only while the block is idle.
// Each item runs through a sequencer around one 65-bit add/subtract unit and
// a deque memory with a single registered read port:
//   accumulate, head check, run sum, best compare, tail check, push.
// The head check repeats for each head entry aged out and the tail check for
// each tail entry popped; each entry leaves the deque once. The next item
// can be accepted only after the previous one has left the push step.
// in_ch.ready is high only between items. A finished result waits in the
// output register; the next item may be accepted meanwhile, but its result
// is held back (the push step stalls) until out_ch takes the previous one.
// After reset the block seeds the deque with (0, 0) in its seed state
// before it raises in_ch.ready.
`default_nettype none

module max_sum_window_limited_subarray_unit #(
  parameter int unsigned MAX_WINDOW = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  mswl_in_if.sink     in_ch,
  mswl_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mswl_pkg::*;

  localparam int unsigned DEPTH = MAX_WINDOW + 1;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
  endfunction

  state_t            state_r, state_nxt;
  logic [SMP_W-1:0]  sample_r, sample_nxt;
  logic [SUM_W-1:0]  prefix_r, prefix_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     tail_r, tail_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  best_r, best_nxt;
  logic [SUM_W-1:0]  run_r, run_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]  out_data_r, out_data_nxt;

  logic [WIN_W-1:0]  window_len;
  logic [IDX_W-1:0]  win_eff;
  logic [IDX_W-1:0]  age;

  alu_req_t          alu_req;
  alu_res_t          alu_res;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  entry_t            wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  entry_t            rd_data;

  mswl_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .window_len (window_len)
  );

  mswl_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  mswl_deque_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    if (window_len == '0) begin
      win_eff = IDX_W'(1);
    end else if (IDX_W'(window_len) > IDX_W'(MAX_WINDOW)) begin
      win_eff = IDX_W'(MAX_WINDOW);
    end else begin
      win_eff = IDX_W'(window_len);
    end
  end

  assign age = idx_r - rd_data.idx;

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.best_sum = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    sample_nxt    = sample_r;
    prefix_nxt    = prefix_r;
    idx_nxt       = idx_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    best_nxt      = best_r;
    run_nxt       = run_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    out_data_nxt  = out_data_r;
    alu_req.op    = ALU_ADD;
    alu_req.a     = prefix_r;
    alu_req.b     = {{(SUM_W-SMP_W){sample_r[SMP_W-1]}}, sample_r};
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = head_r;

    case (state_r)
      ST_SEED: begin
        wr_en     = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          sample_nxt = in_ch.sample;
          if (in_ch.start_req) begin
            prefix_nxt = '0;
            idx_nxt    = '0;
            head_nxt   = '0;
            tail_nxt   = ptr_inc('0);
            cnt_nxt    = CW'(1);
            best_nxt   = SUM_MIN;
            wr_en      = 1'b1;
          end
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        prefix_nxt = alu_res.value;
        idx_nxt    = idx_r + IDX_W'(1);
        rd_en      = 1'b1;
        state_nxt  = ST_HEAD;
      end
      ST_HEAD: begin
        // rd_data holds the head entry
        if (cnt_r != '0 && age > win_eff) begin
          head_nxt = ptr_inc(head_r);
          cnt_nxt  = cnt_r - CW'(1);
          rd_en    = 1'b1;
          rd_addr  = ptr_inc(head_r);
        end else if (cnt_r != '0) begin
          state_nxt = ST_RUN;
        end else begin
          state_nxt = ST_PUSH;
        end
      end
      ST_RUN: begin
        alu_req.op = ALU_SUB;
        alu_req.b  = rd_data.prefix;
        run_nxt    = alu_res.value;
        state_nxt  = ST_BEST;
      end
      ST_BEST: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = best_r;
        alu_req.b  = run_r;
        if (!alu_res.ge) begin
          best_nxt = run_r;
        end
        rd_en     = 1'b1;
        rd_addr   = ptr_dec(tail_r);
        state_nxt = ST_TAIL;
      end
      ST_TAIL: begin
        // rd_data holds the entry just before the tail
        alu_req.op = ALU_SUB;
        alu_req.a  = rd_data.prefix;
        alu_req.b  = prefix_r;
        if (cnt_r != '0 && alu_res.ge) begin
          tail_nxt = ptr_dec(tail_r);
          cnt_nxt  = cnt_r - CW'(1);
          if (cnt_r != CW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = ptr_dec(ptr_dec(tail_r));
          end else begin
            state_nxt = ST_PUSH;
          end
        end else begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid_r || out_ch.ready) begin
          if (cnt_r < CW'(DEPTH)) begin
            wr_en       = 1'b1;
            wr_addr     = tail_r;
            wr_data.idx = idx_r;
            wr_data.prefix = prefix_r;
            tail_nxt    = ptr_inc(tail_r);
            cnt_nxt     = cnt_r + CW'(1);
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = best_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SEED;
      prefix_r    <= '0;
      idx_r       <= '0;
      head_r      <= '0;
      tail_r      <= ptr_inc('0);
      cnt_r       <= CW'(1);
      best_r      <= SUM_MIN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prefix_r    <= prefix_nxt;
      idx_r       <= idx_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    run_r      <= run_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("deque occupancy above depth");

  a_idle_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (cnt_r != '0))
    else $error("deque empty between items");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == ST_ACC))
    else $error("accepted item not processed");

  a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH && state_nxt == ST_IDLE) |=>
      (out_valid_r && out_data_r == $past(best_r)))
    else $error("result not presented after push");
`endif

endmodule

`default_nettype wire

### sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mswl_pkg::*;

  localparam int unsigned MAX_WINDOW  = 255;
  localparam int unsigned DQ_DEPTH    = MAX_WINDOW + 1;
  localparam logic [2:0]  WINDOW_ADDR = 3'd0;
  localparam int          KEEP        = -1;
  localparam int unsigned RAND_ITEMS  = 1950;
  localparam int unsigned PHASE_ITEMS = 240;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned SETTLE      = 300;

  typedef enum {SEQ_MIXED, SEQ_RAMP, SEQ_NOISE} seq_shape_t;

  typedef struct {
    logic signed [31:0] smp;
    bit                 st;
    int                 win;
    bit                 typed;
    logic signed [63:0] sum;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mswl_in_if  in_ch ();
  mswl_out_if out_ch ();

  max_sum_window_limited_subarray_unit #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // directed items; typed sums are the obvious ones, the rest use the predictor
  dir_row_t dir_rows [24] = '{
    '{32'sd5,         1'b0, KEEP, 1'b1, 64'sd5},           // no start since reset
    '{-32'sd3,        1'b0, KEEP, 1'b1, 64'sd5},
    '{-32'sd7,        1'b1, KEEP, 1'b1, -64'sd7},          // restart clears best
    '{32'h7FFFFFFF,   1'b1, KEEP, 1'b1, 64'sd2147483647},
    '{32'h80000000,   1'b1, KEEP, 1'b1, -64'sd2147483648},
    '{-32'sd1,        1'b0, KEEP, 1'b1, -64'sd1},
    '{32'sd10,        1'b1, 0,    1'b1, 64'sd10},          // window 0 acts as 1
    '{32'sd20,        1'b0, KEEP, 1'b1, 64'sd20},
    '{-32'sd5,        1'b0, KEEP, 1'b1, 64'sd20},
    '{32'h7FFFFFFF,   1'b1, 255,  1'b1, 64'sd2147483647},
    '{32'h7FFFFFFF,   1'b0, KEEP, 1'b1, 64'sd4294967294},
    '{32'h80000000,   1'b0, KEEP, 1'b1, 64'sd4294967294},
    '{32'sd1,         1'b0, KEEP, 1'b0, 64'sd0},
    '{32'h80000000,   1'b0, KEEP, 1'b0, 64'sd0},
    '{32'sd3,         1'b1, 2,    1'b1, 64'sd3},
    '{-32'sd1,        1'b0, KEEP, 1'b1, 64'sd3},
    '{32'sd4,         1'b0, KEEP, 1'b1, 64'sd4},
    '{32'sd5,         1'b0, KEEP, 1'b0, 64'sd0},
    '{-32'sd2,        1'b1, KEEP, 1'b1, -64'sd2},
    '{32'sd0,         1'b0, 3,    1'b0, 64'sd0},           // window change mid-sequence
    '{32'sd6,         1'b0, KEEP, 1'b0, 64'sd0},
    '{32'h55555555,   1'b0, KEEP, 1'b0, 64'sd0},
    '{32'hAAAAAAAA,   1'b0, KEEP, 1'b0, 64'sd0},
    '{32'sd0,         1'b1, KEEP, 1'b1, 64'sd0}
  };

  // predictor state
  logic [7:0]         win_reg;
  logic signed [63:0] prefix_sum;
  logic [31:0]        pos_index;
  logic [31:0]        dq_idx [DQ_DEPTH];
  logic signed [63:0] dq_pfx [DQ_DEPTH];
  int unsigned        dq_head;
  int unsigned        dq_tail;
  int unsigned        dq_count;
  logic signed [63:0] best_so_far;

  logic signed [63:0] best_q [$];
  logic signed [63:0] want;

  bit          no_idle;
  bit          hold_out;
  int unsigned n_items;
  int unsigned n_directed;
  int unsigned n_starts;
  int unsigned n_windows;
  int unsigned n_checked;
  int unsigned n_errors;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void seed_deque();
    prefix_sum  = '0;
    pos_index   = '0;
    dq_idx[0]   = '0;
    dq_pfx[0]   = '0;
    dq_head     = 0;
    dq_tail     = 1;
    dq_count    = 1;
    best_so_far = SUM_MIN;
  endfunction

  function automatic int unsigned eff_window();
    if (win_reg == 0) return 1;
    if (win_reg > MAX_WINDOW) return MAX_WINDOW;
    return win_reg;
  endfunction

  function automatic logic signed [63:0] track_best(input logic signed [31:0] smp, input bit st);
    logic [31:0]        span;
    logic signed [63:0] run_sum;
    int unsigned        prev;
    span = eff_window();
    if (st) seed_deque();
    pos_index  = pos_index + 32'd1;
    prefix_sum = prefix_sum + {{32{smp[31]}}, smp};
    // age out entries more than span samples back
    while (dq_count > 0 && (pos_index - dq_idx[dq_head]) > span) begin
      dq_head  = (dq_head + 1) % DQ_DEPTH;
      dq_count = dq_count - 1;
    end
    if (dq_count > 0) begin
      run_sum = prefix_sum - dq_pfx[dq_head];
      if (run_sum > best_so_far) best_so_far = run_sum;
    end
    // keep prefixes strictly rising toward the tail
    prev = (dq_tail + DQ_DEPTH - 1) % DQ_DEPTH;
    while (dq_count > 0 && dq_pfx[prev] >= prefix_sum) begin
      dq_tail  = prev;
      dq_count = dq_count - 1;
      prev     = (dq_tail + DQ_DEPTH - 1) % DQ_DEPTH;
    end
    if (dq_count < DQ_DEPTH) begin
      dq_idx[dq_tail] = pos_index;
      dq_pfx[dq_tail] = prefix_sum;
      dq_tail         = (dq_tail + 1) % DQ_DEPTH;
      dq_count        = dq_count + 1;
    end
    return best_so_far;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] pick_sample();
    int unsigned        r;
    logic signed [31:0] mag;
    r = $urandom_range(0, 99);
    if (r < 40) return $signed($urandom_range(0, 200)) - 32'sd100;
    if (r < 60) return $signed($urandom_range(0, 20000)) - 32'sd10000;
    if (r < 75) return $urandom;
    if (r < 85) begin
      case ($urandom_range(0, 3))
        0: return 32'h7FFFFFFF;
        1: return 32'h80000000;
        2: return 32'h00000000;
        default: return 32'hFFFFFFFF;
      endcase
    end
    mag = 32'h40000000 | $urandom_range(0, 32'h3FFFFFFF);
    return $urandom_range(0, 1) ? mag : -mag;
  endfunction

  task automatic cfg_access(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window(input logic [7:0] w);
    logic [31:0] rd;
    cfg_access(1'b1, WINDOW_ADDR, {24'd0, w}, rd);
    win_reg   = w;
    n_windows = n_windows + 1;
    cfg_access(1'b0, WINDOW_ADDR, '0, rd);
    if (rd[WIN_W-1:0] !== w) begin
      $display("%0t: window_len readback mismatch: expected %0d, got %0d", $time, w,
               rd[WIN_W-1:0]);
      n_errors = n_errors + 1;
    end
  endtask

  task automatic send_item(input logic signed [31:0] smp, input bit st, input bit typed,
                           input logic signed [63:0] typed_sum);
    int unsigned        gap;
    logic signed [63:0] model_sum;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample    <= smp;
    in_ch.start_req <= st;
    do @(posedge clk); while (!in_ch.ready);
    model_sum = track_best(smp, st);
    best_q.push_back(typed ? typed_sum : model_sum);
    n_items = n_items + 1;
    if (st) n_starts = n_starts + 1;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (best_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_sequence(input seq_shape_t shape, input int unsigned len);
    logic signed [31:0] smp;
    bit                 st;
    for (int unsigned k = 0; k < len; k++) begin
      case (shape)
        SEQ_RAMP: begin
          st  = (k == 0);
          // rising prefixes fill the deque, then one big drop empties it
          smp = (k == len - 1) ? 32'sh80000000 : $signed($urandom_range(1, 5000));
        end
        SEQ_NOISE: begin
          st  = ($urandom_range(0, 15) == 0);
          smp = pick_sample();
        end
        default: begin
          st  = (k == 0) && ($urandom_range(0, 9) != 0);
          smp = pick_sample();
        end
      endcase
      send_item(smp, st, 1'b0, '0);
    end
  endtask

  // result side pacing; long hold on request
  initial begin : result_pacer
    int unsigned pause;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        pause = pick_gap();
        out_ch.ready <= (pause == 0);
        repeat ((pause == 0) ? $urandom_range(1, 12) : pause) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (best_q.size() == 0) begin
        $display("%0t: unexpected best_sum: expected none, got %0d", $time, out_ch.best_sum);
        n_errors = n_errors + 1;
      end else begin
        want      = best_q.pop_front();
        n_checked = n_checked + 1;
        if (out_ch.best_sum !== want) begin
          $display("%0t: best_sum mismatch: expected %0d, got %0d", $time, want,
                   out_ch.best_sum);
          n_errors = n_errors + 1;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned budget;
    int unsigned len;
    int unsigned span;
    int unsigned w;
    int unsigned r;
    seq_shape_t  shape;
    in_ch.valid     <= 1'b0;
    in_ch.sample    <= '0;
    in_ch.start_req <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_n   <= 1'b0;
    no_idle  = 1'b0;
    hold_out = 1'b0;
    win_reg  = 8'd1;
    seed_deque();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].win != KEEP) begin
        drain_results();
        set_window(8'(dir_rows[i].win));
      end
      send_item(dir_rows[i].smp, dir_rows[i].st, dir_rows[i].typed, dir_rows[i].sum);
    end
    n_directed = n_items;

    phase = 0;
    while (n_items - n_directed < RAND_ITEMS) begin
      drain_results();
      case (phase)
        0: w = 255;
        1: w = 0;
        2: w = 1;
        default: w = $urandom_range(0, 1) ? $urandom_range(2, 16) : $urandom_range(0, 255);
      endcase
      set_window(8'(w));
      no_idle = (phase == 3);
      if (phase == 4) hold_out = 1'b1;
      span   = eff_window();
      budget = PHASE_ITEMS;
      while (budget > 0 && n_items - n_directed < RAND_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          shape = SEQ_MIXED;
          len   = (r < 56) ? $urandom_range(1, 2 * span + 8) : $urandom_range(1, 300);
          if (len > 300) len = 300;
        end else if (r < 85) begin
          shape = SEQ_RAMP;
          len   = span + $urandom_range(2, 40);
        end else begin
          shape = SEQ_NOISE;
          len   = $urandom_range(1, 60);
        end
        if (len > RAND_ITEMS - (n_items - n_directed)) begin
          len = RAND_ITEMS - (n_items - n_directed);
        end
        run_sequence(shape, len);
        budget = (len >= budget) ? 0 : budget - len;
      end
      phase = phase + 1;
    end
    no_idle = 1'b0;

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (best_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, best_q.size());
      n_errors = n_errors + 1;
    end
    $display("Sent %0d items (%0d directed) across %0d window writes, %0d sequence restarts.",
             n_items, n_directed, n_windows, n_starts);
    $display("Compared %0d results, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("%0t: timeout, %0d results outstanding", $time, best_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
